### rtl/core/assert_macros.svh
// assertion macros used by the queue top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// assertion clocked on clk_i and disabled while rst_ni is low
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// assertion with an explicit clock and active-low reset
`define SPQ_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`endif
`endif

### rtl/core/spq_pkg.sv
// types and constants of the sorted priority queue
`timescale 1ns / 1ps
package spq_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned OccW        = 5;
  localparam int unsigned CapacityDef = 16;

  typedef enum logic [1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_POP_MIN = 2'd1,
    FUNC_POP_MAX = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [DataW-1:0] value;
  } spq_req_t;

  typedef struct packed {
    logic signed [DataW-1:0] removed_value;
    logic [1:0]              status;
    logic [OccW-1:0]         occupancy;
  } spq_rsp_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                    push;
    logic                    pop_min;
    logic signed [DataW-1:0] value;
  } cell_ctrl_t;

endpackage

### rtl/core/spq_cell.sv
// one cell of the sorted chain: holds one entry and trades with its neighbours
`timescale 1ns / 1ps
module spq_cell (
  input  logic                              clk_i,
  input  spq_pkg::cell_ctrl_t               ctrl_i,
  input  logic                              valid_i,
  input  logic                              prev_above_i,
  input  logic signed [spq_pkg::DataW-1:0]  prev_value_i,
  input  logic signed [spq_pkg::DataW-1:0]  next_value_i,
  output logic                              above_o,
  output logic signed [spq_pkg::DataW-1:0]  value_o
);

  logic signed [spq_pkg::DataW-1:0] value_q, value_d;

  // empty cells and larger entries sit above the new value
  assign above_o = !valid_i || (value_q > ctrl_i.value);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.push && above_o) begin
      // first cell above takes the new value, the rest shift up by one
      value_d = prev_above_i ? prev_value_i : ctrl_i.value;
    end else if (ctrl_i.pop_min) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

### rtl/core/sorted_priority_queue_unit.sv
// top level of the sorted priority queue built as a chain of cells
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
// channel | direction | payload             | handshake
// --------+-----------+---------------------+--------------------------
// in      | in        | spq_req_t in_req_i  | in_valid_i / in_stall_o
// out     | out       | spq_rsp_t out_rsp_o | out_valid_o / out_stall_i
//
// one request per cycle while in_stall_o is low: every cell compares its entry with the pushed value
// and looks only at its lower neighbour's flag, so a push, a pop of the
// smallest or a pop of the largest completes in the cycle it is accepted
// the result is registered and sits in the output register in the cycle after acceptance
// reset clears the entry count and the output valid; cell contents need none
// in_stall_o is high only while a result waits and out_stall_i holds it
module sorted_priority_queue_unit #(
  parameter int unsigned Capacity = spq_pkg::CapacityDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  spq_pkg::spq_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output spq_pkg::spq_rsp_t out_rsp_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);

  // entry count, the cells below it hold valid entries
  logic [CntW-1:0] count_q, count_d;

  // output register
  logic              out_valid_q, out_valid_d;
  spq_pkg::spq_rsp_t out_q, out_d;

  logic                             accept;
  logic                             is_push, is_pop_min;
  logic                             full, empty;
  spq_pkg::cell_ctrl_t              ctrl;
  logic [Capacity:0]                valid_ext;
  logic [Capacity-1:0]              above;
  logic [Capacity-1:0]              last;
  logic signed [spq_pkg::DataW-1:0] cell_value [Capacity];
  logic signed [spq_pkg::DataW-1:0] tail_value;
  logic signed [spq_pkg::DataW-1:0] removed;
  logic [1:0]                       status;

  // a new request is taken whenever the output register is free or drains
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_push    = in_req_i.func == spq_pkg::FUNC_PUSH;
  assign is_pop_min = in_req_i.func == spq_pkg::FUNC_POP_MIN;
  assign full       = count_q == CntW'(Capacity);
  assign empty      = count_q == '0;

  // a full push or an empty pop leaves the chain untouched
  assign ctrl.push    = accept && is_push && !full;
  assign ctrl.pop_min = accept && is_pop_min && !empty;
  assign ctrl.value   = in_req_i.value;

  // valid thermometer from the count, with an always-empty slot past the end
  assign valid_ext[Capacity] = 1'b0;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic                             prev_above;
    logic signed [spq_pkg::DataW-1:0] prev_value;
    logic signed [spq_pkg::DataW-1:0] next_value;

    assign valid_ext[i] = count_q > CntW'(i);
    // the tail entry is the valid cell whose upper neighbour is empty
    assign last[i] = valid_ext[i] && !valid_ext[i+1];

    if (i == 0) begin : g_head
      assign prev_above = 1'b0;
      assign prev_value = '0;
    end else begin : g_body
      assign prev_above = above[i-1];
      assign prev_value = cell_value[i-1];
    end

    if (i == Capacity - 1) begin : g_end
      assign next_value = cell_value[i];
    end else begin : g_mid
      assign next_value = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (valid_ext[i]),
      .prev_above_i (prev_above),
      .prev_value_i (prev_value),
      .next_value_i (next_value),
      .above_o      (above[i]),
      .value_o      (cell_value[i])
    );
  end

  // one-hot selection of the tail entry
  always_comb begin
    tail_value = '0;
    for (int i = 0; i < Capacity; i++) begin
      tail_value = tail_value | (cell_value[i] & {spq_pkg::DataW{last[i]}});
    end
  end

  always_comb begin
    count_d = count_q;
    removed = '0;
    status  = spq_pkg::STATUS_OK;
    if (accept) begin
      case (in_req_i.func)
        spq_pkg::FUNC_PUSH: begin
          if (full) begin
            status = spq_pkg::STATUS_FULL;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
        spq_pkg::FUNC_POP_MIN: begin
          if (empty) begin
            status = spq_pkg::STATUS_EMPTY;
          end else begin
            removed = cell_value[0];
            count_d = count_q - CntW'(1);
          end
        end
        spq_pkg::FUNC_POP_MAX: begin
          if (empty) begin
            status = spq_pkg::STATUS_EMPTY;
          end else begin
            removed = tail_value;
            count_d = count_q - CntW'(1);
          end
        end
        default: begin
          // unused operation code: no change
          count_d = count_q;
        end
      endcase
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (accept) begin
      out_valid_d         = 1'b1;
      out_d.removed_value = removed;
      out_d.status        = status;
      out_d.occupancy     = spq_pkg::OccW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // checks on the chain, the count and the output
  `SPQ_ASSERT(a_count_bound, count_q <= CntW'(Capacity), "entry count beyond capacity")
  `SPQ_ASSERT(a_push_grows, ctrl.push |=> count_q == $past(count_q) + CntW'(1), "push lost")
  `SPQ_ASSERT(a_pop_excl, !(ctrl.push && ctrl.pop_min), "push and pop at once")
  `SPQ_ASSERT(a_empty_zero, out_valid_q && out_q.status == spq_pkg::STATUS_EMPTY |-> out_q.removed_value == '0, "empty pop returns data")

  for (genvar i = 0; i + 1 < Capacity; i++) begin : g_order_chk
    `SPQ_ASSERT(a_sorted, valid_ext[i+1] |-> cell_value[i] <= cell_value[i+1], "chain out of order")
  end

endmodule

### sim/tb_sorted_priority_queue_unit.sv
// self-checking testbench of the sorted priority queue with its own queue predictor
`timescale 1ns / 1ps
module tb_sorted_priority_queue_unit;

  localparam int unsigned QUEUE_DEPTH = spq_pkg::CapacityDef;
  localparam int unsigned CYCLE_LIMIT = 200000;
  // code 3 is outside func_e: the block must treat it as a no-op
  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam logic signed [spq_pkg::DataW-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [spq_pkg::DataW-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  spq_pkg::spq_req_t in_req_i;
  logic              out_valid_o;
  logic              out_stall_i;
  spq_pkg::spq_rsp_t out_rsp_o;

  sorted_priority_queue_unit #(
    .Capacity(QUEUE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // predictor state: held values kept in ascending order, smallest at index 0
  logic signed [spq_pkg::DataW-1:0] held_vals [QUEUE_DEPTH];
  int unsigned                      held_count;

  // results still owed by the block, oldest first
  spq_pkg::spq_rsp_t expected_rsps[$];
  spq_pkg::spq_rsp_t want_rsp;

  // idling knobs, changed by the tests while traffic runs
  int unsigned tx_max_gap;
  int unsigned rx_max_gap;
  int unsigned rx_long_hold;

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned req_count;
  int unsigned rsp_count;
  int unsigned push_count;
  int unsigned pop_count;
  int unsigned nop_count;
  int unsigned full_hits;
  int unsigned empty_hits;
  int unsigned peak_fill;

  // clock: 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog against a hung handshake
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_rsps.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // behaviour of one request on the predictor state; pushes go after equal values
  function automatic spq_pkg::spq_rsp_t predict_queue_op(input spq_pkg::spq_req_t req);
    spq_pkg::spq_rsp_t rsp;
    int unsigned       pos;
    rsp        = '0;
    rsp.status = spq_pkg::STATUS_OK;
    case (req.func)
      spq_pkg::FUNC_PUSH: begin
        if (held_count >= QUEUE_DEPTH) begin
          rsp.status = spq_pkg::STATUS_FULL;
        end else begin
          pos = 0;
          while (pos < held_count && held_vals[pos] <= req.value) pos++;
          for (int unsigned i = held_count; i > pos; i--) held_vals[i] = held_vals[i-1];
          held_vals[pos] = req.value;
          held_count++;
        end
      end
      spq_pkg::FUNC_POP_MIN: begin
        if (held_count == 0) begin
          rsp.status = spq_pkg::STATUS_EMPTY;
        end else begin
          rsp.removed_value = held_vals[0];
          for (int unsigned i = 1; i < held_count; i++) held_vals[i-1] = held_vals[i];
          held_count--;
        end
      end
      spq_pkg::FUNC_POP_MAX: begin
        if (held_count == 0) begin
          rsp.status = spq_pkg::STATUS_EMPTY;
        end else begin
          rsp.removed_value = held_vals[held_count-1];
          held_count--;
        end
      end
      default: ;  // unused code leaves the queue alone
    endcase
    rsp.occupancy = held_count[spq_pkg::OccW-1:0];
    return rsp;
  endfunction

  // half full-range values, the rest small values for ties or the extremes
  function automatic logic signed [spq_pkg::DataW-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 8)) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return $signed($urandom());
    endcase
  endfunction

  // operation mix steered by the share of pushes, so the fill level wanders
  function automatic logic [1:0] pick_func(input int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return FUNC_NOP;
    if (roll < 4 + push_pct * 96 / 100) return spq_pkg::FUNC_PUSH;
    return $urandom_range(0, 1) ? spq_pkg::FUNC_POP_MIN : spq_pkg::FUNC_POP_MAX;
  endfunction

  // one request: random gap, then hold valid until accepted
  // valid stays high on return so a following request can go back to back
  task automatic send_req(input logic [1:0] func,
                          input logic signed [spq_pkg::DataW-1:0] value);
    int unsigned       gap;
    spq_pkg::spq_req_t req;
    spq_pkg::spq_rsp_t rsp;
    gap       = $urandom_range(0, tx_max_gap);
    req.func  = func;
    req.value = value;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    rsp = predict_queue_op(req);
    expected_rsps.push_back(rsp);
    req_count++;
    case (func)
      spq_pkg::FUNC_PUSH: push_count++;
      spq_pkg::FUNC_POP_MIN, spq_pkg::FUNC_POP_MAX: pop_count++;
      default: nop_count++;
    endcase
    if (rsp.status == spq_pkg::STATUS_FULL) full_hits++;
    if (rsp.status == spq_pkg::STATUS_EMPTY) empty_hits++;
    if (held_count > peak_fill) peak_fill = held_count;
  endtask

  // sender stops offering and waits until every owed result has been taken
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
  endtask

  // pops and the unused code on an empty queue
  task automatic test_empty_queue();
    send_req(spq_pkg::FUNC_POP_MIN, $signed($urandom()));
    send_req(spq_pkg::FUNC_POP_MAX, $signed($urandom()));
    send_req(FUNC_NOP, $signed($urandom()));
    wait_for_results();
  endtask

  // extremes of the value range, ties, both pops and the unused code
  task automatic test_value_extremes();
    send_req(spq_pkg::FUNC_PUSH, VAL_MAX);
    send_req(spq_pkg::FUNC_PUSH, VAL_MIN);
    send_req(spq_pkg::FUNC_PUSH, '0);
    send_req(spq_pkg::FUNC_PUSH, -1);
    send_req(spq_pkg::FUNC_PUSH, 1);
    send_req(spq_pkg::FUNC_PUSH, VAL_MIN);
    send_req(spq_pkg::FUNC_PUSH, VAL_MAX);
    send_req(spq_pkg::FUNC_POP_MAX, VAL_MIN);
    send_req(spq_pkg::FUNC_POP_MIN, VAL_MAX);
    send_req(FUNC_NOP, VAL_MAX);
    send_req(spq_pkg::FUNC_POP_MIN, '0);
    send_req(spq_pkg::FUNC_POP_MAX, -1);
    wait_for_results();
  endtask

  // fill to capacity, push into the full queue, then empty it past the bottom
  task automatic test_full_queue();
    while (held_count < QUEUE_DEPTH) send_req(spq_pkg::FUNC_PUSH, pick_value());
    send_req(spq_pkg::FUNC_PUSH, VAL_MAX);
    send_req(spq_pkg::FUNC_PUSH, VAL_MIN);
    send_req(FUNC_NOP, pick_value());
    while (held_count != 0)
      send_req($urandom_range(0, 1) ? spq_pkg::FUNC_POP_MIN : spq_pkg::FUNC_POP_MAX,
               pick_value());
    send_req(spq_pkg::FUNC_POP_MIN, pick_value());
    wait_for_results();
  endtask

  // blocks of push-heavy and pop-heavy traffic; some blocks run without idling
  task automatic test_random_traffic(input int unsigned n_blocks);
    int unsigned push_pct;
    for (int unsigned blk = 0; blk < n_blocks; blk++) begin
      push_pct = (blk % 2 == 0) ? 70 : 30;
      if (blk % 4 == 3) begin
        tx_max_gap = 0;
        rx_max_gap = 0;
      end else begin
        tx_max_gap = 15;
        rx_max_gap = 15;
      end
      repeat (30) send_req(pick_func(push_pct), pick_value());
      if ($urandom_range(0, 3) == 0) wait_for_results();
    end
    tx_max_gap = 15;
    rx_max_gap = 15;
    wait_for_results();
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    tx_max_gap   = 0;
    rx_long_hold = 200;
    repeat (24) send_req(pick_func(60), pick_value());
    tx_max_gap = 15;
    wait_for_results();
  endtask

  // receiver: per result a random hold, or the long hold when one is asked for
  initial begin : drive_out_stall
    int unsigned hold;
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_long_hold != 0) begin
        hold         = rx_long_hold;
        rx_long_hold = 0;
      end else begin
        hold = $urandom_range(0, rx_max_gap);
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // each result taken is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rsp_count++;
      if (expected_rsps.size() == 0) begin
        $error("result with nothing expected: removed_value %0d status %0d occupancy %0d",
               out_rsp_o.removed_value, out_rsp_o.status, out_rsp_o.occupancy);
        error_count++;
      end else begin
        want_rsp = expected_rsps.pop_front();
        if (out_rsp_o.removed_value !== want_rsp.removed_value) begin
          $error("removed_value: expected %0d, got %0d", want_rsp.removed_value,
                 out_rsp_o.removed_value);
          error_count++;
        end
        if (out_rsp_o.status !== want_rsp.status) begin
          $error("status: expected %0d, got %0d", want_rsp.status, out_rsp_o.status);
          error_count++;
        end
        if (out_rsp_o.occupancy !== want_rsp.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want_rsp.occupancy,
                 out_rsp_o.occupancy);
          error_count++;
        end
      end
    end
  end

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_req_i     = '0;
    out_stall_i  = 1'b0;
    held_count   = 0;
    tx_max_gap   = 15;
    rx_max_gap   = 15;
    rx_long_hold = 0;
    cycle_count  = 0;
    error_count  = 0;
    req_count    = 0;
    rsp_count    = 0;
    push_count   = 0;
    pop_count    = 0;
    nop_count    = 0;
    full_hits    = 0;
    empty_hits   = 0;
    peak_fill    = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_value_extremes();
    test_full_queue();
    test_random_traffic(15);
    test_output_backpressure();
    test_full_queue();

    wait_for_results();
    repeat (5) @(posedge clk_i);
    $display("run: %0d requests (%0d pushes, %0d pops, %0d no-ops), %0d results checked",
             req_count, push_count, pop_count, nop_count, rsp_count);
    $display("run: %0d pushes refused when full, %0d pops on empty, peak fill %0d of %0d",
             full_hits, empty_hits, peak_fill, QUEUE_DEPTH);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_unit.sv
sim/tb_sorted_priority_queue_unit.sv
